// ----- sv/i2cms_pkg.sv -----
// shared types and constants for the i2c master segment sequencer
// no dependencies; imported by every module of the block

package i2cms_pkg;

    // beat widths on the stream ports
    localparam int IN_W  = 40;
    localparam int OUT_W = 24;

    // operation selector carried in tuser
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_READ  = 2'd1,
        OP_START = 2'd2,
        OP_EVENT = 2'd3
    } op_t;

    // controller action
    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_NACK  = 3'd2,
        ACT_ACK   = 3'd3,
        ACT_STOP  = 3'd4
    } action_t;

    // bus status codes, low three bits cleared
    localparam logic [7:0] ST_NO_INFO   = 8'hF8;
    localparam logic [7:0] ST_START     = 8'h08;
    localparam logic [7:0] ST_RSTART    = 8'h10;
    localparam logic [7:0] ST_SLA_W_ACK = 8'h18;
    localparam logic [7:0] ST_DAT_W_ACK = 8'h28;
    localparam logic [7:0] ST_SLA_W_NAK = 8'h20;
    localparam logic [7:0] ST_DAT_W_NAK = 8'h30;
    localparam logic [7:0] ST_SLA_R_ACK = 8'h40;
    localparam logic [7:0] ST_SLA_R_NAK = 8'h48;
    localparam logic [7:0] ST_DAT_R_ACK = 8'h50;
    localparam logic [7:0] ST_DAT_R_NAK = 8'h58;
    localparam logic [7:0] ST_ARB_LOST  = 8'h38;

    // one registered input item (buffer index travels separately)
    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic [6:0] target;
        logic [4:0] status_hi;
        logic [7:0] rx;
    } item_t;

    // one result item
    typedef struct packed {
        action_t    action;
        logic [7:0] tx;
        logic       busy;
        logic [7:0] read_data;
        logic       rejected;
    } res_t;

endpackage

// ----- sv/i2cms_buffer.sv -----
// segment buffer memory: one write port, one registered read port
// a read that meets a write to the same entry returns the new byte; uses i2cms_pkg

module i2cms_buffer #(
    parameter int BUF_DEPTH = 256,
    localparam int AW = $clog2(BUF_DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);
    import i2cms_pkg::*;

    logic [7:0] mem [BUF_DEPTH];
    logic [7:0] ram_q_reg;
    logic       byp_reg;
    logic [7:0] byp_data_reg;

    // storage array and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            ram_q_reg <= mem[rd_addr];
        end
    end

    // read-during-write bypass flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    // bypass byte
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            byp_data_reg <= wr_data;
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : ram_q_reg;

endmodule

// ----- sv/i2cms_engine.sv -----
// sequencer state and per-item decision logic
// holds segment base, byte index, address byte and a header copy; uses i2cms_pkg

module i2cms_engine #(
    parameter int BUF_DEPTH = 256,
    localparam int AW = $clog2(BUF_DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  i2cms_pkg::item_t    item,
    input  logic [AW-1:0]       item_addr,
    input  logic [7:0]          rd_data,
    output logic                wr_en,
    output logic [AW-1:0]       wr_addr,
    output logic [7:0]          wr_data,
    output logic [AW-1:0]       pos_fwd,
    output i2cms_pkg::res_t     res
);
    import i2cms_pkg::*;

    logic [AW-1:0] base_reg, base_next;
    logic [7:0]    idx_reg, idx_next;
    logic [AW-1:0] idxm_reg, idxm_next;
    logic [7:0]    abyte_reg, abyte_next;
    logic [7:0]    hdr_reg, hdr_next;
    logic [AW-1:0] cur_pos;
    logic [7:0]    idx_inc;
    logic [6:0]    hlen_eff;
    logic [7:0]    status_code;
    logic          wr_req;

    // (a + b) mod depth for two in-range indices
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(BUF_DEPTH))
        begin
            s = s - (AW+1)'(BUF_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // byte index mod depth after an increment of the 8-bit index
    function automatic logic [AW-1:0] inc_mod(input logic [7:0] idx, input logic [AW-1:0] idxm);
        logic [AW-1:0] r;
        if (idx == 8'hFF)
        begin
            r = '0;
        end
        else if (idxm == AW'(BUF_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = idxm + AW'(1);
        end
        return r;
    endfunction

    // decision for the item in the compute stage
    always_comb
    begin
        cur_pos     = wrap_add(base_reg, idxm_reg);
        idx_inc     = idx_reg + 8'd1;
        hlen_eff    = hdr_reg[6:0];
        status_code = {item.status_hi, 3'b000};
        base_next   = base_reg;
        idx_next    = idx_reg;
        idxm_next   = idxm_reg;
        abyte_next  = abyte_reg;
        hdr_next    = hdr_reg;
        wr_req      = 1'b0;
        wr_addr     = cur_pos;
        wr_data     = item.rx;
        res.action    = ACT_NONE;
        res.tx        = 8'd0;
        res.read_data = 8'd0;
        res.rejected  = 1'b0;

        unique case (item.op)
            OP_LOAD:
            begin
                wr_req  = 1'b1;
                wr_addr = item_addr;
                wr_data = item.data;
                if (item_addr == base_reg)
                begin
                    hdr_next = item.data;
                end
            end
            OP_READ:
            begin
                res.read_data = rd_data;
            end
            OP_START:
            begin
                if (abyte_reg != 8'd0)
                begin
                    res.rejected = 1'b1;
                end
                else
                begin
                    abyte_next = {item.target, 1'b0};
                    base_next  = item_addr;
                    hdr_next   = rd_data;
                    res.action = ACT_START;
                end
            end
            OP_EVENT:
            begin
                unique case (status_code)
                    ST_START, ST_RSTART:
                    begin
                        idx_next   = 8'd1;
                        idxm_next  = AW'(1);
                        res.tx     = abyte_reg;
                        res.action = ACT_NACK;
                    end
                    ST_SLA_W_ACK, ST_DAT_W_ACK:
                    begin
                        if (idx_reg < {1'b0, hdr_reg[6:0]})
                        begin
                            res.tx     = rd_data;
                            idx_next   = idx_inc;
                            idxm_next  = inc_mod(idx_reg, idxm_reg);
                            res.action = ACT_NACK;
                        end
                        else
                        begin
                            // segment done: move on to the next header
                            base_next = cur_pos;
                            hdr_next  = rd_data;
                            if (rd_data[7])
                            begin
                                abyte_next = abyte_reg | 8'd1;
                            end
                            if (rd_data[6:0] != 7'd0)
                            begin
                                res.action = ACT_START;
                            end
                            else
                            begin
                                abyte_next = 8'd0;
                                res.action = ACT_STOP;
                            end
                        end
                    end
                    ST_DAT_R_ACK:
                    begin
                        wr_req = 1'b1;
                        if (cur_pos == base_reg)
                        begin
                            hdr_next = item.rx;
                            hlen_eff = item.rx[6:0];
                        end
                        idx_next   = idx_inc;
                        idxm_next  = inc_mod(idx_reg, idxm_reg);
                        res.action = (idx_inc < {1'b0, hlen_eff}) ? ACT_ACK : ACT_NACK;
                    end
                    ST_SLA_R_ACK:
                    begin
                        res.action = (idx_reg < {1'b0, hdr_reg[6:0]}) ? ACT_ACK : ACT_NACK;
                    end
                    ST_DAT_R_NAK:
                    begin
                        wr_req = 1'b1;
                        if (cur_pos == base_reg)
                        begin
                            hdr_next = item.rx;
                        end
                        abyte_next = 8'd0;
                        res.action = ACT_STOP;
                    end
                    ST_ARB_LOST, ST_NO_INFO:
                    begin
                        res.action = ACT_NONE;
                    end
                    default:
                    begin
                        abyte_next = 8'd0;
                        res.action = ACT_STOP;
                    end
                endcase
            end
        endcase

        res.busy = (abyte_next != 8'd0);

        // state only moves when the item leaves the compute stage
        if (!fire)
        begin
            base_next  = base_reg;
            idx_next   = idx_reg;
            idxm_next  = idxm_reg;
            abyte_next = abyte_reg;
            hdr_next   = hdr_reg;
        end
        wr_en   = fire && wr_req;
        pos_fwd = wrap_add(base_next, idxm_next);
    end

    // sequencer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            idx_reg   <= 8'd0;
            idxm_reg  <= '0;
            abyte_reg <= 8'd0;
            hdr_reg   <= 8'd0;
        end
        else
        begin
            base_reg  <= base_next;
            idx_reg   <= idx_next;
            idxm_reg  <= idxm_next;
            abyte_reg <= abyte_next;
            hdr_reg   <= hdr_next;
        end
    end

endmodule

// ----- sv/i2c_master_segment_sequencer.sv -----
// i2c master segment sequencer, top level: input stage, buffer, engine, result register
// depends on i2cms_pkg, i2cms_buffer and i2cms_engine
// an accepted beat is held in the input stage, then offered from the result register
// throughput: one beat per cycle unless the sink holds off, set by the combinational
//   engine between the buffer read register and the result register
// reset: rst_n clears all control and sequencer state at once; the buffer has
//   no reset and holds undefined bytes until loaded, with no clearing pass

module i2c_master_segment_sequencer #(
    parameter int BUF_DEPTH = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // buf_addr[7:0], buf_data[15:8], target_addr[22:16], bus_status[30:23],
    // rx_byte[38:31], zero pad[39]
    input  logic [i2cms_pkg::IN_W-1:0] s_tdata,
    // op[1:0]
    input  logic [1:0]                 s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // action[2:0], tx_byte[10:3], busy_res[11], read_data[19:12],
    // rejected[20], zero pad[23:21]
    output logic [i2cms_pkg::OUT_W-1:0] m_tdata
);
    import i2cms_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);

    logic          accept;
    logic          fire;
    item_t         item_in;
    logic [AW-1:0] addr_in_mod;
    logic          b_valid_reg;
    item_t         item_reg;
    logic [AW-1:0] addr_reg;
    logic          out_valid_reg;
    res_t          out_reg;
    res_t          res;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic [AW-1:0] pos_fwd;

    // byte index mod depth by restoring subtraction (quotient below 16)
    function automatic logic [AW-1:0] addr_mod(input logic [7:0] a);
        logic [11:0] v;
        v = {4'd0, a};
        for (int k = 3; k >= 0; k--)
        begin
            if (v >= 12'(BUF_DEPTH << k))
            begin
                v = v - 12'(BUF_DEPTH << k);
            end
        end
        return v[AW-1:0];
    endfunction

    // handshake
    assign fire     = b_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !b_valid_reg || fire;
    assign accept   = s_tvalid && s_tready;

    // unpack the incoming beat
    always_comb
    begin
        item_in.op        = op_t'(s_tuser);
        item_in.data      = s_tdata[15:8];
        item_in.target    = s_tdata[22:16];
        item_in.status_hi = s_tdata[30:26];
        item_in.rx        = s_tdata[38:31];
        addr_in_mod       = addr_mod(s_tdata[7:0]);
        rd_addr           = (item_in.op == OP_EVENT) ? pos_fwd : addr_in_mod;
    end

    // input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            b_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_in;
            addr_reg <= addr_in_mod;
        end
    end

    i2cms_buffer #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_buffer (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    i2cms_engine #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item_reg),
        .item_addr (addr_reg),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .pos_fwd   (pos_fwd),
        .res       (res)
    );

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= res;
        end
    end

    // pack the outgoing beat
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.rejected, out_reg.read_data, out_reg.busy,
                       out_reg.tx, out_reg.action};

    // input side only stalls when both stages are full and the sink holds off
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (b_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled with room in the pipeline");

    // an accepted beat always occupies the input stage
    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> b_valid_reg)
        else $error("accepted beat lost from the input stage");

    // a rejected start gives no action
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.rejected) |-> (res.action == ACT_NONE && item_reg.op == OP_START))
        else $error("rejected beat carries an action");

    // buffer writes come only from loads and received data
    a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (fire && item_reg.op != OP_READ && item_reg.op != OP_START))
        else $error("buffer write from a read or start beat");

endmodule
